FILE: sv/ratu_pkg.sv
// shared types and constants for the rational add/multiply unit
package ratu_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int DEN_WIDTH  = 31;
    localparam int CNT_WIDTH  = $clog2(WORD_WIDTH + 1);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic        [WORD_WIDTH-1:0] uword_t;

    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam word_t WORD_ONE = word_t'(1);
    localparam word_t WORD_NEG_ONE = {WORD_WIDTH{1'b1}};

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_MUL = 1'b1
    } mode_t;

    typedef struct packed {
        logic  mode;
        word_t num_a;
        word_t den_a;
        word_t num_b;
        word_t den_b;
    } in_word_t;

    typedef struct packed {
        word_t                 res_num;
        logic [DEN_WIDTH-1:0]  res_den;
        logic                  overflow;
    } out_word_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
        logic  ovf;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_GCD,
        ST_DIVW,
        ST_NDONE,
        ST_LMUL,
        ST_L3,
        ST_P1,
        ST_P2,
        ST_SUM,
        ST_MULN,
        ST_MULD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DOP_GCD,
        DOP_NN,
        DOP_ND,
        DOP_L1,
        DOP_L3,
        DOP_L4
    } dop_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } phase_t;

    typedef enum logic {
        CTX_NORM,
        CTX_LCM
    } ctx_t;

endpackage

FILE: sv/ratu_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module ratu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ratu_pkg::div_req_t req,
    output ratu_pkg::div_rsp_t rsp
);
    import ratu_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    uword_t               q_reg, q_next;
    uword_t               r_reg, r_next;
    uword_t               d_reg, d_next;
    logic                 sq_reg, sq_next;
    logic                 sr_reg, sr_next;
    logic                 ov_reg, ov_next;
    logic [WORD_WIDTH:0]  shifted;
    logic                 ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        sr_reg  <= sr_next;
        ov_reg  <= ov_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        ov_next   = ov_reg;
        shifted   = {r_reg, q_reg[WORD_WIDTH-1]};
        ge        = (shifted >= {1'b0, d_reg});
        if (busy_reg) begin
            r_next   = ge ? uword_t'(shifted - {1'b0, d_reg}) : shifted[WORD_WIDTH-1:0];
            q_next   = {q_reg[WORD_WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(WORD_WIDTH);
            q_next    = req.a[WORD_WIDTH-1] ? uword_t'(-req.a) : uword_t'(req.a);
            d_next    = req.b[WORD_WIDTH-1] ? uword_t'(-req.b) : uword_t'(req.b);
            r_next    = '0;
            sq_next   = req.a[WORD_WIDTH-1] ^ req.b[WORD_WIDTH-1];
            sr_next   = req.a[WORD_WIDTH-1];
            ov_next   = (req.a == WORD_MIN) && (req.b == WORD_NEG_ONE);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sq_reg ? word_t'(-q_reg) : word_t'(q_reg);
    assign rsp.rem  = sr_reg ? word_t'(-r_reg) : word_t'(r_reg);
    assign rsp.ovf  = ov_reg;

endmodule

FILE: sv/rational_add_mult_unit.sv
// top level of the rational add/multiply unit
// adds (mode 0) or multiplies (mode 1) two fractions and returns the result
// reduced, with a positive denominator and the sign in the numerator
// s_ channel: one input word per item, taken only while the unit is idle
// m_ channel: one result word per item; overflow marks any wrapped step
// each item runs through a sequencer around one shared iterative divider
// and one combinational word multiplier whose product is registered
// an item runs three normalizations, each a euclid gcd (one division per
// step) and two divisions; add needs one more gcd and three divisions, and
// operands with long euclid chains take longer
// the next item is taken once the result has been taken
// reset returns the sequencer to idle; a stalled receiver holds the result
// word and the unit takes no input until it is accepted
module rational_add_mult_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ratu_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output ratu_pkg::out_word_t m_word
);
    import ratu_pkg::*;

    state_t    state_reg, state_next;
    dop_t      dop_reg, dop_next;
    phase_t    phase_reg, phase_next;
    ctx_t      ctx_reg, ctx_next;
    in_word_t  in_reg, in_next;
    out_word_t out_reg, out_next;
    word_t     nx_reg, nx_next, dx_reg, dx_next;
    word_t     ga_reg, ga_next, gb_reg, gb_next, g_reg, g_next;
    word_t     na_reg, na_next, da_reg, da_next, nb_reg, nb_next, db_reg, db_next;
    word_t     lcd_reg, lcd_next, q1_reg, q1_next, q2_reg, q2_next;
    logic      ovf_reg, ovf_next;

    div_req_t  dreq;
    div_rsp_t  drsp;

    word_t                        mul_a, mul_b;
    logic signed [2*WORD_WIDTH-1:0] prod;
    word_t                        mul_res;
    logic                         mul_ovf;
    word_t                        sum;
    logic                         sum_ovf;
    logic                         zero_in;
    word_t                        n1, d1, gabs;

    ratu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign prod    = mul_a * mul_b;
    assign mul_res = prod[WORD_WIDTH-1:0];
    assign mul_ovf = prod[2*WORD_WIDTH-1:WORD_WIDTH-1] != {(WORD_WIDTH+1){prod[WORD_WIDTH-1]}};
    assign sum     = q1_reg + q2_reg;
    assign sum_ovf = (q1_reg[WORD_WIDTH-1] == q2_reg[WORD_WIDTH-1]) &&
                     (sum[WORD_WIDTH-1] != q1_reg[WORD_WIDTH-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        dop_reg   <= dop_next;
        phase_reg <= phase_next;
        ctx_reg   <= ctx_next;
        in_reg    <= in_next;
        out_reg   <= out_next;
        nx_reg    <= nx_next;
        dx_reg    <= dx_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        g_reg     <= g_next;
        na_reg    <= na_next;
        da_reg    <= da_next;
        nb_reg    <= nb_next;
        db_reg    <= db_next;
        lcd_reg   <= lcd_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
        ovf_reg   <= ovf_next;
    end

    always_comb begin
        state_next = state_reg;
        dop_next   = dop_reg;
        phase_next = phase_reg;
        ctx_next   = ctx_reg;
        in_next    = in_reg;
        out_next   = out_reg;
        nx_next    = nx_reg;
        dx_next    = dx_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        g_next     = g_reg;
        na_next    = na_reg;
        da_next    = da_reg;
        nb_next    = nb_reg;
        db_next    = db_reg;
        lcd_next   = lcd_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        ovf_next   = ovf_reg;
        dreq       = '0;
        mul_a      = na_reg;
        mul_b      = nb_reg;
        zero_in    = (nx_reg == '0) || (dx_reg == '0);
        n1         = zero_in ? word_t'(0) : nx_reg;
        d1         = zero_in ? WORD_ONE : dx_reg;
        gabs       = ga_reg[WORD_WIDTH-1] ? word_t'(-ga_reg) : ga_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_word;
                    nx_next    = s_word.num_a;
                    dx_next    = s_word.den_a;
                    phase_next = PH_A;
                    ovf_next   = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (d1[WORD_WIDTH-1]) begin
                    if (n1 == WORD_MIN || d1 == WORD_MIN) begin
                        ovf_next = 1'b1;
                    end
                    nx_next = word_t'(-n1);
                    dx_next = word_t'(-d1);
                    ga_next = word_t'(-n1);
                    gb_next = word_t'(-d1);
                end else begin
                    nx_next = n1;
                    dx_next = d1;
                    ga_next = n1;
                    gb_next = d1;
                end
                ctx_next   = CTX_NORM;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (gb_reg == '0) begin
                    if (ga_reg == WORD_MIN) begin
                        ovf_next = 1'b1;
                    end
                    g_next     = (gabs == '0) ? WORD_ONE : gabs;
                    dreq.start = 1'b1;
                    dreq.b     = (gabs == '0) ? WORD_ONE : gabs;
                    if (ctx_reg == CTX_NORM) begin
                        dreq.a   = nx_reg;
                        dop_next = DOP_NN;
                    end else begin
                        dreq.a   = da_reg;
                        dop_next = DOP_L1;
                    end
                end else begin
                    dreq.start = 1'b1;
                    dreq.a     = ga_reg;
                    dreq.b     = gb_reg;
                    dop_next   = DOP_GCD;
                end
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (drsp.done) begin
                    case (dop_reg)
                        DOP_GCD: begin
                            ga_next    = gb_reg;
                            gb_next    = drsp.rem;
                            state_next = ST_GCD;
                        end
                        DOP_NN: begin
                            nx_next    = drsp.quot;
                            ovf_next   = ovf_reg | drsp.ovf;
                            dreq.start = 1'b1;
                            dreq.a     = dx_reg;
                            dreq.b     = g_reg;
                            dop_next   = DOP_ND;
                        end
                        DOP_ND: begin
                            dx_next    = drsp.quot;
                            ovf_next   = ovf_reg | drsp.ovf;
                            state_next = ST_NDONE;
                        end
                        DOP_L1: begin
                            q1_next    = drsp.quot;
                            ovf_next   = ovf_reg | drsp.ovf;
                            state_next = ST_LMUL;
                        end
                        DOP_L3: begin
                            q1_next    = drsp.quot;
                            ovf_next   = ovf_reg | drsp.ovf;
                            dreq.start = 1'b1;
                            dreq.a     = lcd_reg;
                            dreq.b     = db_reg;
                            dop_next   = DOP_L4;
                        end
                        DOP_L4: begin
                            q2_next    = drsp.quot;
                            ovf_next   = ovf_reg | drsp.ovf;
                            state_next = ST_P1;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NDONE: begin
                case (phase_reg)
                    PH_A: begin
                        na_next    = nx_reg;
                        da_next    = dx_reg;
                        nx_next    = in_reg.num_b;
                        dx_next    = in_reg.den_b;
                        phase_next = PH_B;
                        state_next = ST_NORM;
                    end
                    PH_B: begin
                        nb_next = nx_reg;
                        db_next = dx_reg;
                        if (in_reg.mode == MODE_MUL) begin
                            state_next = ST_MULN;
                        end else begin
                            ga_next    = da_reg;
                            gb_next    = dx_reg;
                            ctx_next   = CTX_LCM;
                            state_next = ST_GCD;
                        end
                    end
                    default: begin
                        out_next.res_num  = nx_reg;
                        out_next.res_den  = dx_reg[DEN_WIDTH-1:0];
                        out_next.overflow = ovf_reg;
                        state_next        = ST_OUT;
                    end
                endcase
            end
            ST_LMUL: begin
                mul_a      = q1_reg;
                mul_b      = db_reg;
                lcd_next   = mul_res;
                ovf_next   = ovf_reg | mul_ovf;
                state_next = ST_L3;
            end
            ST_L3: begin
                dreq.start = 1'b1;
                dreq.a     = lcd_reg;
                dreq.b     = da_reg;
                dop_next   = DOP_L3;
                state_next = ST_DIVW;
            end
            ST_P1: begin
                mul_a      = na_reg;
                mul_b      = q1_reg;
                q1_next    = mul_res;
                ovf_next   = ovf_reg | mul_ovf;
                state_next = ST_P2;
            end
            ST_P2: begin
                mul_a      = nb_reg;
                mul_b      = q2_reg;
                q2_next    = mul_res;
                ovf_next   = ovf_reg | mul_ovf;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                nx_next    = sum;
                dx_next    = lcd_reg;
                ovf_next   = ovf_reg | sum_ovf;
                phase_next = PH_R;
                state_next = ST_NORM;
            end
            ST_MULN: begin
                mul_a      = na_reg;
                mul_b      = nb_reg;
                nx_next    = mul_res;
                ovf_next   = ovf_reg | mul_ovf;
                state_next = ST_MULD;
            end
            ST_MULD: begin
                mul_a      = da_reg;
                mul_b      = db_reg;
                dx_next    = mul_res;
                ovf_next   = ovf_reg | mul_ovf;
                phase_next = PH_R;
                state_next = ST_NORM;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_word = out_reg;

endmodule

FILE: tb/tb_rational_add_mult_unit.sv
// testbench for the rational add/multiply unit: directed and random fractions
module tb_rational_add_mult_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ratu_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    out_word_t expected_q[$];
    int        mismatches = 0;
    bit        ovf_flag;

    rational_add_mult_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint wrap32(longint v);
        return longint'(signed'(v[31:0]));
    endfunction

    function automatic longint neg_w(longint a);
        if (a == SMIN) begin
            ovf_flag = 1'b1;
            return a;
        end
        return -a;
    endfunction

    function automatic longint add_w(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SMAX || s < SMIN) ovf_flag = 1'b1;
        return wrap32(s);
    endfunction

    function automatic longint mul_w(longint a, longint b);
        longint p;
        p = a * b;
        if (p > SMAX || p < SMIN) ovf_flag = 1'b1;
        return wrap32(p);
    endfunction

    function automatic longint div_w(longint a, longint b);
        if (b == -1) return neg_w(a);
        return a / b;
    endfunction

    function automatic longint gcd_w(longint a, longint b);
        longint r;
        while (b != 0) begin
            r = (b == -1) ? 0 : a % b;
            a = b;
            b = r;
        end
        return (a < 0) ? neg_w(a) : a;
    endfunction

    function automatic void reduce(inout longint n, inout longint d);
        longint g;
        if (d == 0 || n == 0) begin
            n = 0;
            d = 1;
        end
        if (d < 0) begin
            n = neg_w(n);
            d = neg_w(d);
        end
        g = gcd_w(n, d);
        if (g == 0) g = 1;
        n = div_w(n, g);
        d = div_w(d, g);
    endfunction

    function automatic out_word_t fraction_result(in_word_t w);
        longint na, da, nb, db, rn, rd, g, lcd;
        out_word_t r;
        ovf_flag = 1'b0;
        na = w.num_a; da = w.den_a; nb = w.num_b; db = w.den_b;
        reduce(na, da);
        reduce(nb, db);
        if (mode_t'(w.mode) == MODE_MUL) begin
            rn = mul_w(na, nb);
            rd = mul_w(da, db);
        end else begin
            g = gcd_w(da, db);
            if (g == 0) g = 1;
            lcd = mul_w(div_w(da, g), db);
            rn = add_w(mul_w(na, div_w(lcd, da)), mul_w(nb, div_w(lcd, db)));
            rd = lcd;
        end
        reduce(rn, rd);
        r.res_num = rn[31:0];
        r.res_den = rd[30:0];
        r.overflow = ovf_flag;
        return r;
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        expected_q.push_back(fraction_result(w));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_fracs(mode_t md, longint na, longint da, longint nb, longint db);
        in_word_t w;
        w.mode = md;
        w.num_a = na[31:0]; w.den_a = da[31:0];
        w.num_b = nb[31:0]; w.den_b = db[31:0];
        send_word(w);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    function automatic word_t rand_operand();
        case ($urandom_range(0, 5))
            0: return word_t'($urandom_range(0, 40)) - 20;
            1: return word_t'($urandom_range(0, 2000)) - 1000;
            2: return word_t'($urandom_range(0, 200000)) - 100000;
            3: return word_t'($urandom_range(0, 6)) + SMIN[31:0] - 3;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        mode_t md;
        for (int m = 0; m < 2; m++) begin
            md = mode_t'(m);
            send_fracs(md, 1, 2, 1, 3);
            send_fracs(md, 0, 5, 3, 7);
            send_fracs(md, 4, 0, -6, 8);
            send_fracs(md, 3, -4, -5, -6);
            send_fracs(md, SMIN, 1, 1, 1);
            send_fracs(md, 1, SMIN, SMAX, 1);
            send_fracs(md, SMAX, SMAX, SMIN, SMIN);
            send_fracs(md, SMIN, -1, 2, 3);
            send_fracs(md, 65536, 3, 65536, 5);
            send_fracs(md, 1, 65536, 1, 65537);
            send_fracs(md, -1, -1, SMAX, 2);
        end
        wait_drained();
    endtask

    task automatic test_random();
        in_word_t w;
        for (int i = 0; i < 1500; i++) begin
            w.mode = 1'($urandom_range(0, 1));
            w.num_a = rand_operand(); w.den_a = rand_operand();
            w.num_b = rand_operand(); w.den_b = rand_operand();
            send_word(w);
            if (i == 700) wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", m_word);
            end else begin
                if (m_word !== expected_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected %p actual %p", expected_q[0], m_word);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        wait_drained();
        repeat (2000) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
sv/ratu_pkg.sv
sv/ratu_div.sv
sv/rational_add_mult_unit.sv
tb/tb_rational_add_mult_unit.sv
